### sv/sor_pkg.sv
// ----------------------------------------------------------------------------
// sor_pkg
// shared constants and types for the sigma outlier replacement block
// ----------------------------------------------------------------------------
`default_nettype none

package sor_pkg;

  localparam int DEPTH_DEF  = 64;
  localparam int SAMPLE_W   = 32;
  localparam int THR_W      = 16;
  localparam logic [THR_W-1:0] THR_RESET = 16'd768;  // 3.0 in q8.8
  localparam int MIN_BLOCK  = 3;
  localparam int FRAC_SH    = 16;

  // sum of squares is split in chunks for the threshold product
  localparam int CH_W  = 24;
  localparam int CH_N  = 3;
  localparam int S_W   = CH_W * CH_N;
  localparam int TT_W  = 2 * THR_W;
  localparam int RHS_W = S_W + TT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVGO,
    ST_DIV,
    ST_VAR,
    ST_RHS,
    ST_OUT
  } st_t;

endpackage

`default_nettype wire

### sv/sor_cell.sv
// ----------------------------------------------------------------------------
// sor_cell
// one storage cell of the sample ring, passes its word on when shifted
// ----------------------------------------------------------------------------
`default_nettype none

module sor_cell (
  input  wire logic                          clk,
  input  wire logic                          shift,
  input  wire logic [sor_pkg::SAMPLE_W-1:0]  d,
  output logic      [sor_pkg::SAMPLE_W-1:0]  q
);

  logic [sor_pkg::SAMPLE_W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

### sv/sor_div.sv
// ----------------------------------------------------------------------------
// sor_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sor_div #(
  parameter int DVD_W = 38,
  parameter int DVS_W = 7
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic      [DVD_W-1:0] quotient,
  output logic      [DVS_W-1:0] remainder
);

  localparam int CT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;
  logic [CT_W-1:0]  cnt_r;
  logic             run_r;
  logic             done_r;

  logic [DVS_W:0]   trial;
  logic             ge;
  logic [DVS_W:0]   diff;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CT_W'(DVD_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (run_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], ge};
      // remainder stays below the divisor, top bit drops
      rem_r <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

### sv/sigma_outlier_replace.sv
// ----------------------------------------------------------------------------
// sigma_outlier_replace
// replaces samples beyond a sigma limit of their block by the block mean
// ----------------------------------------------------------------------------
// a non-final word is stored and busy stays low. a final word starts the
// block: bit-serial mean division, a variance pass, the threshold product,
// then an output pass with one result per cycle for each stored word.
// a block holds busy until its output pass ends, so no new word is taken
// meanwhile; results cannot be stalled. reset clears count, sum, overflow,
// sets the threshold to 3.0.
`default_nettype none

module sigma_outlier_replace #(
  parameter int DEPTH = sor_pkg::DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [sor_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic                              in_last,
  output logic                                   out_strobe,
  output logic signed [sor_pkg::SAMPLE_W-1:0]    out_value,
  output logic                                   out_replaced,
  output logic                                   out_block_end,
  output logic                                   out_overflow,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [sor_pkg::THR_W-1:0]         cfg_data
);

  localparam int SW    = sor_pkg::SAMPLE_W;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = SW + $clog2(DEPTH);
  localparam int SQ_W  = 2 * SW;
  localparam int LHS_W = SQ_W + CNT_W;
  localparam int PR_W  = sor_pkg::CH_W + sor_pkg::TT_W;

  sor_pkg::st_t st_r, st_nxt;

  logic [CNT_W-1:0]              cnt_r;
  logic signed [SUM_W-1:0]       sum_r;
  logic                          ovf_r;
  logic [sor_pkg::THR_W-1:0]     thr_r;
  logic signed [SW-1:0]          mean_r;
  logic [sor_pkg::TT_W-1:0]      tt_r;
  logic [sor_pkg::S_W-1:0]       s_r;
  logic [sor_pkg::RHS_W-1:0]     rhs_r;
  logic [PR_W-1:0]               prod_r;
  logic [1:0]                    step_r;
  logic [CNT_W-1:0]              rot_r;
  logic                          va_r, vb_r, vc_r;
  logic                          la_r, lb_r, lc_r;
  logic [SW-1:0]                 xa_r, xb_r, xc_r;
  logic [SW-1:0]                 ad_r;
  logic [SQ_W-1:0]               sq_r;
  logic [LHS_W-1:0]              lhs_r;
  logic                          out_strobe_r;
  logic [SW-1:0]                 out_value_r;
  logic                          out_replaced_r, out_block_end_r, out_overflow_r;

  // fsm outputs
  logic busy_c, div_start, ring_en, blk_done;

  logic acc, store, full;
  logic [SW-1:0] cq [DEPTH];
  logic [SW-1:0] tap;
  logic [SW-1:0] c0_d;
  logic          rot_done;
  logic          in_window;

  logic              div_done;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [SUM_W-1:0]  sum_mag;
  logic [SUM_W-1:0]  q_adj;
  logic [SUM_W-1:0]  mean_full;

  logic signed [SW:0] dd;
  logic [SW:0]        dd_mag;
  logic               rep;
  logic [sor_pkg::RHS_W-1:0] lhs_ext;

  assign full     = cnt_r == CNT_W'(DEPTH);
  assign acc      = start && !busy_c;
  assign store    = acc && !full;
  assign rot_done = rot_r == CNT_W'(DEPTH);
  assign tap      = cq[DEPTH-1];
  assign c0_d     = store ? in_sample : tap;
  // the stored words sit in the last cnt_r positions of each rotation
  assign in_window = ({1'b0, rot_r} + {1'b0, cnt_r}) >= (CNT_W+1)'(DEPTH);

  // ring of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sor_cell u_cell (
      .clk   (clk),
      .shift (store || ring_en),
      .d     ((i == 0) ? c0_d : cq[(i == 0) ? 0 : i-1]),
      .q     (cq[i])
    );
  end

  assign sum_mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  sor_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (sum_mag),
    .divisor   (cnt_r),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  // floor division: round the magnitude up for a negative sum
  assign q_adj     = quo + SUM_W'(sum_r[SUM_W-1] && (rem != '0));
  assign mean_full = sum_r[SUM_W-1] ? (~q_adj + 1'b1) : q_adj;

  assign dd     = $signed({tap[SW-1], tap}) - $signed({mean_r[SW-1], mean_r});
  assign dd_mag = dd[SW] ? (~dd + 1'b1) : dd;

  assign lhs_ext = sor_pkg::RHS_W'({lhs_r, sor_pkg::FRAC_SH'(0)});
  assign rep     = (cnt_r >= CNT_W'(sor_pkg::MIN_BLOCK)) && (lhs_ext > rhs_r);

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      sor_pkg::ST_IDLE:  if (acc && in_last) st_nxt = sor_pkg::ST_DIVGO;
      sor_pkg::ST_DIVGO: st_nxt = sor_pkg::ST_DIV;
      sor_pkg::ST_DIV:   if (div_done) st_nxt = sor_pkg::ST_VAR;
      sor_pkg::ST_VAR:   if (rot_done && !va_r && !vb_r) st_nxt = sor_pkg::ST_RHS;
      sor_pkg::ST_RHS:   if (step_r == 2'd3) st_nxt = sor_pkg::ST_OUT;
      sor_pkg::ST_OUT: begin
        if (rot_done && !va_r && !vb_r && !vc_r) st_nxt = sor_pkg::ST_IDLE;
      end
      default:           st_nxt = sor_pkg::ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    busy_c    = 1'b1;
    div_start = 1'b0;
    ring_en   = 1'b0;
    blk_done  = 1'b0;
    unique case (st_r)
      sor_pkg::ST_IDLE:  busy_c = 1'b0;
      sor_pkg::ST_DIVGO: div_start = 1'b1;
      sor_pkg::ST_DIV:   ;
      sor_pkg::ST_VAR:   ring_en = !rot_done;
      sor_pkg::ST_RHS:   ;
      sor_pkg::ST_OUT: begin
        ring_en  = !rot_done;
        blk_done = rot_done && !va_r && !vb_r && !vc_r;
      end
      default:           busy_c = 1'b0;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= sor_pkg::ST_IDLE;
      cnt_r        <= '0;
      sum_r        <= '0;
      ovf_r        <= 1'b0;
      thr_r        <= sor_pkg::THR_RESET;
      rot_r        <= '0;
      step_r       <= '0;
      va_r         <= 1'b0;
      vb_r         <= 1'b0;
      vc_r         <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid) begin
        thr_r <= cfg_data;
      end
      if (blk_done) begin
        cnt_r <= '0;
        sum_r <= '0;
        ovf_r <= 1'b0;
      end else if (store) begin
        cnt_r <= cnt_r + 1'b1;
        sum_r <= sum_r + SUM_W'(in_sample);
      end else if (acc) begin
        ovf_r <= 1'b1;
      end
      if (st_r == sor_pkg::ST_DIVGO || st_r == sor_pkg::ST_RHS) begin
        rot_r <= '0;
      end else if (ring_en) begin
        rot_r <= rot_r + 1'b1;
      end
      step_r       <= (st_r == sor_pkg::ST_RHS) ? step_r + 1'b1 : 2'd0;
      va_r         <= ring_en && in_window;
      vb_r         <= va_r;
      vc_r         <= vb_r && (st_r == sor_pkg::ST_OUT);
      out_strobe_r <= vc_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (div_done) begin
      mean_r <= mean_full[SW-1:0];
    end
    if (st_r == sor_pkg::ST_DIVGO) begin
      tt_r  <= thr_r * thr_r;
      s_r   <= '0;
      rhs_r <= '0;
    end else if (st_r == sor_pkg::ST_VAR && vb_r) begin
      s_r <= s_r + sor_pkg::S_W'(sq_r);
    end else if (st_r == sor_pkg::ST_RHS) begin
      if (step_r != 2'd3) begin
        prod_r <= s_r[sor_pkg::S_W-1 -: sor_pkg::CH_W] * tt_r;
        s_r    <= s_r << sor_pkg::CH_W;
      end
      if (step_r != 2'd0) begin
        rhs_r <= (rhs_r << sor_pkg::CH_W) + sor_pkg::RHS_W'(prod_r);
      end
    end
    // per-word pipe: deviation, square, scaled square, compare
    xa_r <= tap;
    la_r <= ring_en && (rot_r == CNT_W'(DEPTH - 1));
    ad_r <= dd_mag[SW-1:0];
    xb_r <= xa_r;
    lb_r <= la_r;
    sq_r <= ad_r * ad_r;
    xc_r <= xb_r;
    lc_r <= lb_r;
    lhs_r <= sq_r * cnt_r;
    out_value_r     <= rep ? mean_r : xc_r;
    out_replaced_r  <= rep;
    out_block_end_r <= lc_r;
    out_overflow_r  <= ovf_r;
  end

  assign busy          = busy_c;
  assign cfg_ready     = 1'b1;
  assign out_strobe    = out_strobe_r;
  assign out_value     = out_value_r;
  assign out_replaced  = out_replaced_r;
  assign out_block_end = out_block_end_r;
  assign out_overflow  = out_overflow_r;

endmodule

`default_nettype wire

### sv/sor_checker.sv
// ----------------------------------------------------------------------------
// sor_checker
// port-level checks of block framing for sigma_outlier_replace
// ----------------------------------------------------------------------------
`default_nettype none

module sor_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic in_last,
  input wire logic out_strobe,
  input wire logic out_block_end
);

  // results only come while a block is being worked on
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result word while idle");

  // the block-end word is the last of its block
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_block_end |=> !out_strobe)
    else $error("result word after block end");

  // going idle only right after the block-end word
  a_idle_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> $past(out_strobe && out_block_end))
    else $error("idle without block end");

  // a non-final word leaves the block ready
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_last |=> !busy)
    else $error("busy after non-final word");

endmodule

bind sigma_outlier_replace sor_checker u_sor_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_last       (in_last),
  .out_strobe    (out_strobe),
  .out_block_end (out_block_end)
);

`default_nettype wire
